>>> hdl/cie_pep_pkg.sv
// Package with the payload types, phase codes and constants of the CIE pointer-encoding parser.
package cie_pep_pkg;

    localparam int MAX_AUG_LEN = 16;
    localparam int AUG_IDX_W   = (MAX_AUG_LEN > 1) ? $clog2(MAX_AUG_LEN) : 1;
    localparam int AUG_CNT_W   = $clog2(MAX_AUG_LEN + 1);

    localparam logic [3:0] PTR_BYTES_RESET = 4'd8;

    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_ABSOLUTE  = 2'd1;
    localparam logic [1:0] STATUS_MALFORMED = 2'd2;

    localparam logic [7:0] CH_Z = 8'h7a;
    localparam logic [7:0] CH_L = 8'h4c;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_R = 8'h52;

    localparam logic [7:0] ENC_ABSPTR = 8'h00;
    localparam logic [7:0] ENC_OMIT   = 8'hff;

    typedef enum logic [12:0] {
        PH_IDLE    = 13'b0000000000001,
        PH_LEN     = 13'b0000000000010,
        PH_ID      = 13'b0000000000100,
        PH_VER     = 13'b0000000001000,
        PH_AUG     = 13'b0000000010000,
        PH_CODEAL  = 13'b0000000100000,
        PH_DATAAL  = 13'b0000001000000,
        PH_RETREG  = 13'b0000010000000,
        PH_SKIPLEB = 13'b0000100000000,
        PH_SKIPN   = 13'b0001000000000,
        PH_PENC    = 13'b0010000000000,
        PH_RBYTE   = 13'b0100000000000,
        PH_WALK    = 13'b1000000000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_start;
        logic       buffer_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pointer_encoding;
        logic [1:0] parse_status;
    } out_item_t;

endpackage

>>> hdl/cie_pointer_encoding_parser.sv
// Top level of the CIE pointer-encoding parser: byte sequencer, letter walker and result register.
//
// The parser takes one record byte per transfer, one transfer per cycle while it is ready. After
// the byte that completes the return register or a skipped augmentation field, a single letter
// walker steps through the stored augmentation string one letter per cycle until it reaches a
// letter that consumes bytes or the end of the string; in_ready is low during that walk.
// The result register holds one result; in_ready is also low while a result waits there
// and out_ready is low.
module cie_pointer_encoding_parser
    import cie_pep_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item,
    input  logic      cfg_write,
    input  logic [3:0] cfg_data
);

    phase_t               phase_reg, phase_next;
    logic [3:0]           ptr_bytes_reg;
    logic [1:0]           field_cnt_reg, field_cnt_next;
    logic [31:0]          remain_reg, remain_next;
    logic                 ver1_reg, ver1_next;
    logic [7:0]           aug_chars_reg [MAX_AUG_LEN];
    logic [AUG_CNT_W-1:0] aug_len_reg, aug_len_next;
    logic [AUG_CNT_W-1:0] aug_pos_reg, aug_pos_next;
    logic [3:0]           skip_reg, skip_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;
    logic                 in_fire;
    logic                 aug_store;

    assign in_ready  = (phase_reg != PH_WALK) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        phase_t               cur;
        logic [31:0]          base_rem;
        logic [1:0]           base_cnt;
        logic [AUG_CNT_W-1:0] base_len;
        logic [7:0]           b;
        logic [7:0]           ch;
        logic [3:0]           skip_dec;
        logic                 field_done;
        logic                 letter_hit;
        logic                 emit;
        logic [7:0]           emit_enc;
        logic [1:0]           emit_status;

        phase_next     = phase_reg;
        field_cnt_next = field_cnt_reg;
        remain_next    = remain_reg;
        ver1_next      = ver1_reg;
        aug_len_next   = aug_len_reg;
        aug_pos_next   = aug_pos_reg;
        skip_next      = skip_reg;
        last_next      = last_reg;
        aug_store      = 1'b0;
        field_done     = 1'b0;
        letter_hit     = 1'b0;
        emit           = 1'b0;
        emit_enc       = 8'h00;
        emit_status    = STATUS_MALFORMED;
        b              = in_item.data_byte;
        cur            = phase_reg;
        base_rem       = remain_reg;
        base_cnt       = field_cnt_reg;
        base_len       = aug_len_reg;
        skip_dec       = (skip_reg != 4'd0) ? skip_reg - 4'd1 : 4'd0;
        ch             = aug_chars_reg[aug_pos_reg[AUG_IDX_W-1:0]];

        if (phase_reg == PH_WALK)
        begin
            if (aug_pos_reg < aug_len_reg)
            begin
                aug_pos_next = aug_pos_reg + AUG_CNT_W'(1);
                letter_hit   = 1'b1;
                case (ch)
                    CH_Z: phase_next = PH_SKIPLEB;
                    CH_L:
                    begin
                        phase_next = PH_SKIPN;
                        skip_next  = 4'd1;
                    end
                    CH_P: phase_next = PH_PENC;
                    CH_R: phase_next = PH_RBYTE;
                    default: letter_hit = 1'b0;
                endcase
                if (letter_hit && last_reg)
                begin
                    emit = 1'b1;
                end
            end
            else
            begin
                emit        = 1'b1;
                emit_status = STATUS_ABSOLUTE;
            end
        end
        else if (in_fire && (in_item.record_start || phase_reg != PH_IDLE))
        begin
            if (in_item.record_start)
            begin
                cur          = PH_LEN;
                base_rem     = 32'd0;
                base_cnt     = 2'd0;
                base_len     = '0;
                ver1_next    = 1'b0;
                aug_len_next = '0;
                aug_pos_next = '0;
                skip_next    = 4'd0;
                phase_next   = PH_LEN;
            end
            if (cur == PH_LEN)
            begin
                remain_next    = {b, base_rem[31:8]};
                field_cnt_next = base_cnt + 2'd1;
                if (base_cnt == 2'd3)
                begin
                    phase_next = PH_ID;
                end
            end
            else if (remain_reg == 32'd0)
            begin
                emit = 1'b1;
            end
            else
            begin
                remain_next = remain_reg - 32'd1;
                unique case (cur)
                    PH_ID:
                    begin
                        if (b != 8'h00)
                        begin
                            emit = 1'b1;
                        end
                        field_cnt_next = field_cnt_reg + 2'd1;
                        if (field_cnt_reg == 2'd3)
                        begin
                            phase_next = PH_VER;
                        end
                    end
                    PH_VER:
                    begin
                        if (b != 8'h01 && b != 8'h03)
                        begin
                            emit = 1'b1;
                        end
                        ver1_next  = (b == 8'h01);
                        phase_next = PH_AUG;
                    end
                    PH_AUG:
                    begin
                        if (b == 8'h00)
                        begin
                            phase_next = PH_CODEAL;
                        end
                        else if (base_len >= AUG_CNT_W'(MAX_AUG_LEN))
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            aug_store    = 1'b1;
                            aug_len_next = base_len + AUG_CNT_W'(1);
                        end
                    end
                    PH_CODEAL: phase_next = PH_DATAAL;
                    PH_DATAAL:
                    begin
                        if (!b[7])
                        begin
                            phase_next = PH_RETREG;
                        end
                    end
                    PH_RETREG: field_done = ver1_reg || !b[7];
                    PH_SKIPLEB: field_done = !b[7];
                    PH_SKIPN:
                    begin
                        skip_next  = skip_dec;
                        field_done = (skip_dec == 4'd0);
                    end
                    PH_PENC:
                    begin
                        case (b[3:0]) inside
                            4'h1, 4'h9: phase_next = PH_SKIPLEB;
                            4'h2, 4'ha:
                            begin
                                skip_next  = 4'd2;
                                phase_next = PH_SKIPN;
                            end
                            4'h3, 4'hb:
                            begin
                                skip_next  = 4'd4;
                                phase_next = PH_SKIPN;
                            end
                            4'h4, 4'hc:
                            begin
                                skip_next  = 4'd8;
                                phase_next = PH_SKIPN;
                            end
                            default:
                            begin
                                if (b[3:0] == 4'h8 || b == ENC_ABSPTR || b == ENC_OMIT)
                                begin
                                    if (ptr_bytes_reg == 4'd0)
                                    begin
                                        field_done = 1'b1;
                                    end
                                    else
                                    begin
                                        skip_next  = ptr_bytes_reg;
                                        phase_next = PH_SKIPN;
                                    end
                                end
                                else
                                begin
                                    emit = 1'b1;
                                end
                            end
                        endcase
                    end
                    PH_RBYTE:
                    begin
                        emit        = 1'b1;
                        emit_enc    = b;
                        emit_status = STATUS_FOUND;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
            if (!emit)
            begin
                if (field_done)
                begin
                    phase_next = PH_WALK;
                    last_next  = in_item.buffer_last;
                end
                else if (in_item.buffer_last && phase_next != PH_IDLE)
                begin
                    emit = 1'b1;
                end
            end
        end

        if (emit)
        begin
            phase_next = PH_IDLE;
        end

        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (emit)
        begin
            out_valid_next                 = 1'b1;
            out_item_next.pointer_encoding = emit_enc;
            out_item_next.parse_status     = emit_status;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            ptr_bytes_reg <= PTR_BYTES_RESET;
            field_cnt_reg <= 2'd0;
            remain_reg    <= 32'd0;
            ver1_reg      <= 1'b0;
            aug_len_reg   <= '0;
            aug_pos_reg   <= '0;
            skip_reg      <= 4'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            field_cnt_reg <= field_cnt_next;
            remain_reg    <= remain_next;
            ver1_reg      <= ver1_next;
            aug_len_reg   <= aug_len_next;
            aug_pos_reg   <= aug_pos_next;
            skip_reg      <= skip_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                ptr_bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        if (aug_store)
        begin
            aug_chars_reg[aug_len_next[AUG_IDX_W-1:0] - AUG_IDX_W'(1)] <= in_item.data_byte;
        end
    end

    // The output register is always empty while the letter walker runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WALK) |-> !out_valid_reg)
        else $error("result pending during letter walk");

    // Only a found R carries a nonzero encoding.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.parse_status != STATUS_FOUND)
            |-> (out_item_reg.pointer_encoding == 8'h00))
        else $error("nonzero encoding on a result without R");

    // The walk position never passes the stored string length.
    assert property (@(posedge clk) disable iff (!rst_n)
        aug_pos_reg <= aug_len_reg)
        else $error("augmentation position beyond string length");

    // A result register that is not taken keeps its content.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_item_reg)))
        else $error("pending result lost or changed");

endmodule
